@@ rtl/core/swt_pkg.sv @@
package swt_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int ID_BITS     = 20;

    // Port field widths
    localparam int ID_FIELD_W = 20;
    localparam int WT_W       = 32;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 3;

    // Derived widths
    localparam int KEY_W     = (ID_BITS < ID_FIELD_W) ? ID_BITS : ID_FIELD_W;
    localparam int IDX_W     = $clog2(TABLE_DEPTH);
    localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
    localparam int SUM_W     = WT_W + $clog2(TABLE_DEPTH);
    localparam int FRAC_BITS = 16;
    localparam int QUO_W     = FRAC_BITS + 1;
    localparam int DIV_CNT_W = $clog2(QUO_W);

    // Opcodes
    localparam logic [OP_W-1:0] OP_ADD        = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD_ABSENT = 2'd1;
    localparam logic [OP_W-1:0] OP_NORM       = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_ACCUM    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NORM     = 3'd4;

    // One table entry
    typedef struct packed {
        logic [KEY_W-1:0]       key;
        logic signed [WT_W-1:0] wt;
    } t_entry;

    // Table memory access: one write and one read
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_entry           wdata;
        logic [IDX_W-1:0] raddr;
    } t_mem_req;

    // Divider request and response
    typedef struct packed {
        logic             start;
        logic [WT_W-1:0]  mag;
        logic [SUM_W-1:0] sum;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quo;
    } t_div_rsp;

endpackage

@@ rtl/core/sparse_weight_table_l1_normalize.sv @@
// Add weight / add if absent: scan entries in key order, then shift entries up and insert if absent;
// the result strobe is registered and comes in the cycle after the last step.
// Normalize: sum the L1 magnitudes, then per entry one memory read plus a 17-step restoring
// divider; with a zero sum each entry is emitted unchanged. Empty table: no result is emitted.
// One item at a time through the single-read, single-write table memory; busy holds off start.
// Synchronous active-low reset clears the entry count and control; table contents stay undefined.
module sparse_weight_table_l1_normalize import swt_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    input  logic [OP_W-1:0]              i_opcode,
    input  logic [ID_FIELD_W-1:0]        i_word_id,
    input  logic signed [WT_W-1:0]       i_weight_in,
    output logic                         busy,
    output logic                         o_strobe,
    output logic [STATUS_W-1:0]          o_status,
    output logic [ID_FIELD_W-1:0]        o_entry_id,
    output logic signed [WT_W-1:0]       o_entry_weight,
    output logic                         o_last
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SRCH  = 7'b0000010,
        S_SHIFT = 7'b0000100,
        S_PUT   = 7'b0001000,
        S_SUM   = 7'b0010000,
        S_NLD   = 7'b0100000,
        S_DIV   = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [OP_W-1:0]        r_op, n_op;
    logic [KEY_W-1:0]       r_key, n_key;
    logic signed [WT_W-1:0] r_win, n_win;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic [IDX_W-1:0]       r_pos, n_pos;
    logic [SUM_W-1:0]       r_sum, n_sum;
    logic [KEY_W-1:0]       r_ekey, n_ekey;
    logic                   r_neg, n_neg;

    logic                   r_strobe, n_strobe;
    logic [STATUS_W-1:0]    r_status, n_status;
    logic [KEY_W-1:0]       r_id, n_id;
    logic signed [WT_W-1:0] r_wt, n_wt;
    logic                   r_last, n_last;

    t_mem_req mem_req;
    t_entry   rd_data;
    t_div_req div_req;
    t_div_rsp div_rsp;

    logic [CNT_W-1:0] idx_nx;
    logic [CNT_W-1:0] count_m1;
    logic             is_last;
    logic             is_full;
    logic             hit;
    logic             above;
    logic [WT_W-1:0]  q_ext;
    logic [WT_W-1:0]  norm_wt;

    function automatic logic signed [WT_W-1:0] f_sat_add(
        input logic signed [WT_W-1:0] a,
        input logic signed [WT_W-1:0] b
    );
        logic signed [WT_W:0] s;
        s = {a[WT_W-1], a} + {b[WT_W-1], b};
        if (s[WT_W] != s[WT_W-1]) begin
            return s[WT_W] ? {1'b1, {(WT_W-1){1'b0}}} : {1'b0, {(WT_W-1){1'b1}}};
        end
        return s[WT_W-1:0];
    endfunction

    function automatic logic [WT_W-1:0] f_mag(input logic signed [WT_W-1:0] w);
        return w[WT_W-1] ? unsigned'(~w + WT_W'(1)) : unsigned'(w);
    endfunction

    swt_mem u_mem (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    swt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Position helpers
    assign idx_nx   = CNT_W'(r_idx) + CNT_W'(1);
    assign count_m1 = r_count - CNT_W'(1);
    assign is_last  = (idx_nx == r_count);
    assign is_full  = (r_count == CNT_W'(TABLE_DEPTH));
    assign hit      = (rd_data.key == r_key);
    assign above    = (rd_data.key > r_key);

    // Apply sign to the divider quotient
    assign q_ext   = WT_W'(div_rsp.quo);
    assign norm_wt = r_neg ? (~q_ext + WT_W'(1)) : q_ext;

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_key    = r_key;
        n_win    = r_win;
        n_count  = r_count;
        n_idx    = r_idx;
        n_pos    = r_pos;
        n_sum    = r_sum;
        n_ekey   = r_ekey;
        n_neg    = r_neg;
        n_strobe = 1'b0;
        n_status = r_status;
        n_id     = r_id;
        n_wt     = r_wt;
        n_last   = r_last;

        mem_req.we    = 1'b0;
        mem_req.waddr = r_idx;
        mem_req.wdata = rd_data;
        mem_req.raddr = r_idx + IDX_W'(1);

        div_req.start = 1'b0;
        div_req.mag   = f_mag(rd_data.wt);
        div_req.sum   = r_sum;

        unique case (r_state)
            S_IDLE: begin
                mem_req.raddr = '0;
                if (start) begin
                    n_op  = i_opcode;
                    n_key = KEY_W'(i_word_id);
                    n_win = i_weight_in;
                    n_idx = '0;
                    unique case (i_opcode) inside
                        OP_ADD, OP_ADD_ABSENT: begin
                            if (r_count == '0) begin
                                n_pos   = '0;
                                n_state = S_PUT;
                            end else begin
                                n_state = S_SRCH;
                            end
                        end
                        OP_NORM: begin
                            n_sum = '0;
                            if (r_count != '0) begin
                                n_state = S_SUM;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // Scan in key order until the key is found or passed, or the last entry is read
            S_SRCH: begin
                if (hit) begin
                    n_strobe = 1'b1;
                    n_id     = r_key;
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                    if (r_op == OP_ADD) begin
                        mem_req.we       = 1'b1;
                        mem_req.wdata.wt = f_sat_add(rd_data.wt, r_win);
                        n_status         = ST_ACCUM;
                        n_wt             = f_sat_add(rd_data.wt, r_win);
                    end else begin
                        n_status = ST_PRESENT;
                        n_wt     = rd_data.wt;
                    end
                end else if (above || is_last) begin
                    if (is_full) begin
                        n_strobe = 1'b1;
                        n_status = ST_FULL;
                        n_id     = r_key;
                        n_wt     = '0;
                        n_last   = 1'b1;
                        n_state  = S_IDLE;
                    end else if (!above) begin
                        n_pos   = r_count[IDX_W-1:0];
                        n_state = S_PUT;
                    end else begin
                        n_pos         = r_idx;
                        mem_req.raddr = count_m1[IDX_W-1:0];
                        n_idx         = count_m1[IDX_W-1:0];
                        n_state       = S_SHIFT;
                    end
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end

            // Move entries up by one, from the top down to the insert point
            S_SHIFT: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = r_idx + IDX_W'(1);
                mem_req.wdata = rd_data;
                if (r_idx == r_pos) begin
                    n_state = S_PUT;
                end else begin
                    mem_req.raddr = r_idx - IDX_W'(1);
                    n_idx         = r_idx - IDX_W'(1);
                end
            end

            // Write the new entry
            S_PUT: begin
                mem_req.we       = 1'b1;
                mem_req.waddr    = r_pos;
                mem_req.wdata.key = r_key;
                mem_req.wdata.wt  = r_win;
                n_count  = r_count + CNT_W'(1);
                n_strobe = 1'b1;
                n_status = ST_INSERTED;
                n_id     = r_key;
                n_wt     = r_win;
                n_last   = 1'b1;
                n_state  = S_IDLE;
            end

            // Accumulate the L1 sum over all entries
            S_SUM: begin
                n_sum = r_sum + SUM_W'(f_mag(rd_data.wt));
                if (is_last) begin
                    mem_req.raddr = '0;
                    n_idx         = '0;
                    n_state       = S_NLD;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end

            // Entry loaded: emit it as is, or start its division
            S_NLD: begin
                n_ekey = rd_data.key;
                n_neg  = rd_data.wt[WT_W-1];
                if (r_sum == '0) begin
                    n_strobe = 1'b1;
                    n_status = ST_NORM;
                    n_id     = rd_data.key;
                    n_wt     = rd_data.wt;
                    n_last   = is_last;
                    if (is_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end else begin
                    div_req.start = 1'b1;
                    n_state       = S_DIV;
                end
            end

            // Write back the normalized weight and emit it
            S_DIV: begin
                if (div_rsp.done) begin
                    mem_req.we        = 1'b1;
                    mem_req.waddr     = r_idx;
                    mem_req.wdata.key = r_ekey;
                    mem_req.wdata.wt  = signed'(norm_wt);
                    n_strobe = 1'b1;
                    n_status = ST_NORM;
                    n_id     = r_ekey;
                    n_wt     = signed'(norm_wt);
                    n_last   = is_last;
                    if (is_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = S_NLD;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_key    <= n_key;
        r_win    <= n_win;
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_sum    <= n_sum;
        r_ekey   <= n_ekey;
        r_neg    <= n_neg;
        r_status <= n_status;
        r_id     <= n_id;
        r_wt     <= n_wt;
        r_last   <= n_last;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_strobe       = r_strobe;
    assign o_status       = r_status;
    assign o_entry_id     = ID_FIELD_W'(r_id);
    assign o_entry_weight = r_wt;
    assign o_last         = r_last;

endmodule

@@ rtl/core/swt_mem.sv @@
module swt_mem import swt_pkg::*; (
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_entry   o_rd_data
);

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rd_data;

    // Write one entry, read one entry with registered data
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rd_data <= r_mem[i_req.raddr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/core/swt_div.sv @@
module swt_div import swt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [SUM_W-1:0]     r_rem;
    logic                 r_inb;
    logic [QUO_W-1:0]     r_quo;
    logic [SUM_W-1:0]     r_dvs;

    logic [SUM_W:0]   trial;
    logic [SUM_W:0]   diff;
    logic             qbit;
    logic [SUM_W-1:0] n_rem;

    // One restoring step: shift in a dividend bit, subtract if it fits
    always_comb begin
        trial = {r_rem, r_inb};
        diff  = trial - {1'b0, r_dvs};
        qbit  = (trial >= {1'b0, r_dvs});
        n_rem = qbit ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
    end

    // Control: count the quotient bits, pulse done after the last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath: the quotient has one integer bit, set only when mag equals sum, since mag never exceeds sum
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_cnt <= DIV_CNT_W'(QUO_W - 1);
            r_rem <= SUM_W'(i_req.mag >> 1);
            r_inb <= i_req.mag[0];
            r_quo <= '0;
            r_dvs <= i_req.sum;
        end else if (r_busy) begin
            r_cnt <= r_cnt - DIV_CNT_W'(1);
            r_rem <= n_rem;
            r_inb <= 1'b0;
            r_quo <= {r_quo[QUO_W-2:0], qbit};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

@@ rtl/core/swt_chk.sv @@
module swt_chk import swt_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   start,
    input logic [OP_W-1:0]        i_opcode,
    input logic                   busy,
    input logic                   o_strobe,
    input logic [STATUS_W-1:0]    o_status,
    input logic [ID_FIELD_W-1:0]  o_entry_id,
    input logic signed [WT_W-1:0] o_entry_weight,
    input logic                   o_last
);

    // Single-result operations always close their transfer
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_status != ST_NORM) |-> o_last)
        else $error("single result without last");

    // An accepted add makes the block busy
    a_add_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && ((i_opcode == OP_ADD) || (i_opcode == OP_ADD_ABSENT)) |=> busy)
        else $error("add accepted without going busy");

    // More normalized entries follow, so the block stays busy
    a_norm_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_status == ST_NORM) && !o_last |-> busy)
        else $error("normalize stream ended early");

    // Results only come out of work that was in progress
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result without preceding work");

    // Emitted fields are known whenever a result is strobed
    a_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !$isunknown({o_status, o_entry_id, o_entry_weight, o_last}))
        else $error("unknown result fields");

endmodule

bind sparse_weight_table_l1_normalize swt_chk u_swt_chk (.*);
